@@ src/lcrt_pkg.sv @@
// Package for the longest consecutive run tracker.
// Holds default sizes and field widths shared by the top level and the adder unit.
// No dependencies.
`default_nettype none

package lcrt_pkg;

  // Default value width; the run table has 2**VALUE_BITS entries.
  localparam int VALUE_BITS_DEF = 12;

  // Port widths fixed by the interface.
  localparam int VALUE_W   = 12;
  localparam int LONGEST_W = 13;

  // Width of the epoch tag stored with every table entry.
  localparam int EPOCH_BITS = 6;

  // Control for the shared adder: subtract selects a - b, otherwise a + b.
  typedef struct packed {
    logic subtract;
  } alu_ctrl_t;

endpackage

`default_nettype wire

@@ src/lcrt_alu.sv @@
// Shared adder/subtractor used by the run tracker sequencer.
// Depends on lcrt_pkg for the control struct and the default width.
`default_nettype none

module lcrt_alu #(
  parameter int LEN_W = lcrt_pkg::VALUE_BITS_DEF + 1
) (
  input  wire  lcrt_pkg::alu_ctrl_t ctrl,
  input  wire  logic [LEN_W-1:0]    a,
  input  wire  logic [LEN_W-1:0]    b,
  output logic [LEN_W-1:0]          y
);
  import lcrt_pkg::*;

  logic [LEN_W-1:0] b_eff;

  // Two's complement subtract reuses the same carry chain.
  always_comb begin
    b_eff = ctrl.subtract ? ~b : b;
    y     = a + b_eff + {{(LEN_W-1){1'b0}}, ctrl.subtract};
  end

endmodule

`default_nettype wire

@@ src/longest_consecutive_run_tracker.sv @@
// Longest consecutive run tracker: a new value steps through RDV, CHKV, GETL, GETR, SUM,
// WRV, WRL, WRR and DONE, a duplicate through RDV, CHKV and DONE; with the single table port
// a request is taken only once the last result is loaded for output. A sweep that takes no
// request clears the table after reset and on every 2**EPOCH_BITS-th request with first set.
// Depends on lcrt_pkg and lcrt_alu.
`default_nettype none

module longest_consecutive_run_tracker #(
  parameter int VALUE_BITS = lcrt_pkg::VALUE_BITS_DEF
) (
  input  wire  logic                           clk,
  input  wire  logic                           rst,
  input  wire  logic                           in_valid,
  output logic                                 in_ready,
  input  wire  logic                           first,
  input  wire  logic [lcrt_pkg::VALUE_W-1:0]   value,
  input  wire  logic                           last,
  output logic                                 out_valid,
  input  wire  logic                           out_ready,
  output logic [lcrt_pkg::LONGEST_W-1:0]       longest,
  output logic                                 duplicate,
  output logic                                 final_res
);
  import lcrt_pkg::*;

  localparam int LEN_W   = VALUE_BITS + 1;
  localparam int ENTRY_W = EPOCH_BITS + LEN_W;
  localparam int DEPTH   = 1 << VALUE_BITS;

  localparam logic [VALUE_BITS-1:0] V_MAX     = {VALUE_BITS{1'b1}};
  localparam logic [EPOCH_BITS-1:0] EPOCH_MAX = {EPOCH_BITS{1'b1}};
  localparam logic [LEN_W-1:0]      LEN_ONE   = {{(LEN_W-1){1'b0}}, 1'b1};

  // Sequencer states.
  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_RDV   = 4'd2;
  localparam logic [3:0] S_CHKV  = 4'd3;
  localparam logic [3:0] S_GETL  = 4'd4;
  localparam logic [3:0] S_GETR  = 4'd5;
  localparam logic [3:0] S_SUM   = 4'd6;
  localparam logic [3:0] S_WRV   = 4'd7;
  localparam logic [3:0] S_WRL   = 4'd8;
  localparam logic [3:0] S_WRR   = 4'd9;
  localparam logic [3:0] S_DONE  = 4'd10;

  logic [3:0]            state;
  logic [EPOCH_BITS-1:0] epoch;
  logic [VALUE_BITS-1:0] clr_cnt;
  logic                  item_pend;
  logic [VALUE_BITS-1:0] cur_v;
  logic                  cur_last;
  logic                  dup_flag;
  logic [LEN_W-1:0]      left_len;
  logic [LEN_W-1:0]      right_len;
  logic [LEN_W-1:0]      merged;
  logic [LEN_W-1:0]      best;
  logic [VALUE_BITS-1:0] wr_addr;

  // Run table: epoch tag and run length per value.
  logic [ENTRY_W-1:0]    mem [DEPTH];
  logic [ENTRY_W-1:0]    rdata;
  logic [VALUE_BITS-1:0] mem_addr;
  logic                  mem_we;
  logic [ENTRY_W-1:0]    mem_wdata;

  alu_ctrl_t             alu_ctrl;
  logic [LEN_W-1:0]      alu_a;
  logic [LEN_W-1:0]      alu_b;
  logic [LEN_W-1:0]      alu_y;

  logic                  rd_present;
  logic [LEN_W-1:0]      rd_len;
  logic                  out_free;

  // An entry counts only if it was written in the current epoch with a nonzero length.
  assign rd_len     = rdata[LEN_W-1:0];
  assign rd_present = (rdata[ENTRY_W-1 -: EPOCH_BITS] == epoch) && (rd_len != '0);
  assign in_ready   = (state == S_IDLE);
  assign out_free   = !out_valid || out_ready;

  lcrt_alu #(
    .LEN_W(LEN_W)
  ) u_alu (
    .ctrl(alu_ctrl),
    .a   (alu_a),
    .b   (alu_b),
    .y   (alu_y)
  );

  // Operand selection for the shared adder and the table port.
  always_comb begin
    alu_ctrl.subtract = 1'b0;
    alu_a             = LEN_W'(cur_v);
    alu_b             = LEN_ONE;
    mem_addr          = cur_v;
    mem_we            = 1'b0;
    mem_wdata         = {epoch, merged};
    unique case (state)
      S_CLEAR: begin
        mem_addr  = clr_cnt;
        mem_we    = 1'b1;
        mem_wdata = '0;
      end
      S_CHKV: begin
        alu_ctrl.subtract = 1'b1;
        mem_addr          = alu_y[VALUE_BITS-1:0];
      end
      S_GETL: begin
        mem_addr = alu_y[VALUE_BITS-1:0];
      end
      S_GETR: begin
        alu_a = left_len;
      end
      S_SUM: begin
        alu_a = merged;
        alu_b = right_len;
      end
      S_WRV: begin
        alu_ctrl.subtract = 1'b1;
        alu_b             = left_len;
        mem_we            = 1'b1;
      end
      S_WRL: begin
        alu_b    = right_len;
        mem_addr = wr_addr;
        mem_we   = (left_len != '0);
      end
      S_WRR: begin
        mem_addr = wr_addr;
        mem_we   = (right_len != '0);
      end
      default: begin
      end
    endcase
  end

  // Single-port table with registered read data.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    rdata <= mem[mem_addr];
  end

  // Datapath registers, loaded by the sequencer.
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        cur_v    <= VALUE_BITS'(value);
        cur_last <= last;
      end
      S_CHKV: begin
        dup_flag <= rd_present;
      end
      S_GETL: begin
        left_len <= (rd_present && (cur_v != '0)) ? rd_len : '0;
      end
      S_GETR: begin
        right_len <= (rd_present && (cur_v != V_MAX)) ? rd_len : '0;
        merged    <= alu_y;
      end
      S_SUM: begin
        merged <= alu_y;
      end
      S_WRV, S_WRL: begin
        wr_addr <= alu_y[VALUE_BITS-1:0];
      end
      default: begin
      end
    endcase
  end

  // Sequencer, epoch, best length and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      epoch     <= '0;
      clr_cnt   <= '0;
      item_pend <= 1'b0;
      best      <= LEN_ONE;
      out_valid <= 1'b0;
    end else begin
      // In the done state the result register is reloaded rather than emptied.
      if (out_valid && out_ready && (state != S_DONE)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == V_MAX) begin
            state     <= item_pend ? S_RDV : S_IDLE;
            item_pend <= 1'b0;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            if (first && (epoch == EPOCH_MAX)) begin
              // Tags are about to repeat, so wipe the table first.
              best      <= LEN_ONE;
              epoch     <= '0;
              clr_cnt   <= '0;
              item_pend <= 1'b1;
              state     <= S_CLEAR;
            end else begin
              state <= S_RDV;
              if (first) begin
                best  <= LEN_ONE;
                epoch <= epoch + 1'b1;
              end
            end
          end
        end
        S_RDV: begin
          state <= S_CHKV;
        end
        S_CHKV: begin
          state <= rd_present ? S_DONE : S_GETL;
        end
        S_GETL: begin
          state <= S_GETR;
        end
        S_GETR: begin
          state <= S_SUM;
        end
        S_SUM: begin
          state <= S_WRV;
        end
        S_WRV: begin
          state <= S_WRL;
        end
        S_WRL: begin
          state <= S_WRR;
        end
        S_WRR: begin
          if (merged > best) begin
            best <= merged;
          end
          state <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Result payload is captured as the result register is loaded.
  always_ff @(posedge clk) begin
    if ((state == S_DONE) && out_free) begin
      longest   <= LONGEST_W'(best);
      duplicate <= dup_flag;
      final_res <= cur_last;
    end
  end

  // A result only appears after the sequencer finishes a request.
  a_out_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == S_DONE)
    else $error("result appeared outside the done state");

  // No request is taken in the cycle after reset: the clearing sweep runs first.
  a_clear_after_reset: assert property (@(posedge clk)
    $past(rst) && !rst |-> !in_ready)
    else $error("request taken before table clear");

  // The best length never drops to zero.
  a_best_nonzero: assert property (@(posedge clk) disable iff (rst)
    $past(!rst) |-> best != '0)
    else $error("best length is zero");

  // After the last endpoint write, best covers the merged run.
  a_best_covers_merge: assert property (@(posedge clk) disable iff (rst)
    state == S_WRR |=> best >= merged)
    else $error("best length below merged run");

endmodule

`default_nettype wire
